>>> sv/ufs_pkg.sv
// Shared types, codes and constants for the upstream failover selector.
// No dependencies; imported by every module of the block.
package ufs_pkg;

    localparam int MAX_UPSTREAMS_DEF = 4;
    localparam int TIME_W            = 32;
    localparam int FAIL_W            = 2;
    localparam int HEALTH_W          = 2;
    localparam int COUNT_W           = 3;
    localparam int INDEX_W           = 2;

    localparam logic [FAIL_W-1:0] DOWN_LIMIT    = 2'd3;
    localparam logic [TIME_W-1:0] BACKOFF_RESET = 32'd30000;

    // Operation codes of a request
    localparam logic [1:0] OP_SELECT  = 2'd0;
    localparam logic [1:0] OP_FAIL    = 2'd1;
    localparam logic [1:0] OP_SUCCESS = 2'd2;

    // Health codes
    localparam logic [HEALTH_W-1:0] HEALTH_OK      = 2'd0;
    localparam logic [HEALTH_W-1:0] HEALTH_SUSPECT = 2'd1;
    localparam logic [HEALTH_W-1:0] HEALTH_DOWN    = 2'd2;

    // Configuration register indexes
    localparam logic REG_COUNT   = 1'b0;
    localparam logic REG_BACKOFF = 1'b1;

    // Write enables from the sequencer into the breaker store
    typedef struct packed {
        logic fail_we;
        logic down_we;
    } t_store_wr;

    function automatic logic [HEALTH_W-1:0] health_of(input logic [FAIL_W-1:0] fail);
        if (fail == '0) begin
            return HEALTH_OK;
        end
        return (fail >= DOWN_LIMIT) ? HEALTH_DOWN : HEALTH_SUSPECT;
    endfunction

endpackage

>>> sv/upstream_failover_selector.sv
// Top level: failover selector sequencer, config registers, output register.
// Depends on ufs_pkg, ufs_breaker_store and ufs_time_alu.
//
//  channel   | handshake                   | payload
//  ----------+-----------------------------+------------------------------------------
//  request   | i_valid / o_ready           | i_operation, i_upstream_index, i_now_ms
//  result    | o_valid / i_ready           | o_chosen_index, o_health_code, o_all_down,
//            |                             | o_index_invalid, o_active_count
//  config    | i_cfg_valid / o_cfg_ready   | i_cfg_index, i_cfg_data
//
// A select request steps through the scan, which reads one server per cycle through the
// single store port and the shared time adder, then through the arm state when a down server
// is probed (its down-until time is rewritten). Failure/success go through the update state,
// and through the arm state when the failure trips the breaker. One request is in flight at a time.
// Synchronous active-low reset clears all breaker state; count resets to 1 and
// backoff to 30000 ms. A result held by a stalled consumer stays in the output
// register; the sequencer waits in its done state until the register frees up.
module upstream_failover_selector import ufs_pkg::*; #(
    parameter int MAX_UPSTREAMS = MAX_UPSTREAMS_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    // request
    input  logic                i_valid,
    output logic                o_ready,
    input  logic [1:0]          i_operation,
    input  logic [INDEX_W-1:0]  i_upstream_index,
    input  logic [TIME_W-1:0]   i_now_ms,
    // result
    output logic                o_valid,
    input  logic                i_ready,
    output logic [INDEX_W-1:0]  o_chosen_index,
    output logic [HEALTH_W-1:0] o_health_code,
    output logic                o_all_down,
    output logic                o_index_invalid,
    output logic [COUNT_W-1:0]  o_active_count,
    // configuration
    input  logic                i_cfg_valid,
    output logic                o_cfg_ready,
    input  logic                i_cfg_index,
    input  logic [TIME_W-1:0]   i_cfg_data
);

    localparam int IW = (MAX_UPSTREAMS > 1) ? $clog2(MAX_UPSTREAMS) : 1;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_UPDATE,
        S_ARM,
        S_DONE
    } t_state;

    t_state               r_state;
    logic [1:0]           r_op;
    logic [TIME_W-1:0]    r_now;
    logic [COUNT_W-1:0]   r_cnt;
    logic [IW-1:0]        r_k;
    logic [IW-1:0]        r_start;
    logic [COUNT_W-1:0]   r_step;
    logic [INDEX_W-1:0]   r_chosen;
    logic [HEALTH_W-1:0]  r_health;
    logic                 r_all_down;
    logic                 r_invalid;

    logic                 r_o_valid;
    logic [INDEX_W-1:0]   r_o_chosen;
    logic [HEALTH_W-1:0]  r_o_health;
    logic                 r_o_all_down;
    logic                 r_o_invalid;
    logic [COUNT_W-1:0]   r_o_count;

    logic [COUNT_W-1:0]   r_cfg_count;
    logic [TIME_W-1:0]    r_backoff;

    // store and adder hookup
    t_store_wr            st_wr;
    logic [FAIL_W-1:0]    st_fail_wdata;
    logic [FAIL_W-1:0]    st_fail;
    logic [TIME_W-1:0]    st_down;
    logic                 alu_sub;
    logic [TIME_W-1:0]    alu_b;
    logic [TIME_W-1:0]    alu_sum;

    logic [COUNT_W-1:0]   eff_cnt;
    logic [COUNT_W-1:0]   start_mod;
    logic [FAIL_W-1:0]    n_fail;
    logic                 idx_in_range;
    logic                 k_last;
    logic                 step_last;

    // Zero count means one server; clamp to the storage depth.
    always_comb begin
        eff_cnt = r_cfg_count;
        if (r_cfg_count == '0) begin
            eff_cnt = COUNT_W'(1);
        end else if (32'(r_cfg_count) > MAX_UPSTREAMS) begin
            eff_cnt = COUNT_W'(MAX_UPSTREAMS);
        end
    end

    // start % count: index is at most 3, so three conditional subtracts do it
    always_comb begin
        start_mod = COUNT_W'(i_upstream_index);
        for (int i = 0; i < 3; i++) begin
            if (start_mod >= eff_cnt) begin
                start_mod = start_mod - eff_cnt;
            end
        end
    end

    assign idx_in_range = (32'(i_upstream_index) < MAX_UPSTREAMS);
    assign k_last       = (32'(r_k) + 1 == 32'(r_cnt));
    assign step_last    = (32'(r_step) + 1 == 32'(r_cnt));

    // next failure count for failure/success requests
    always_comb begin
        n_fail = st_fail;
        if (r_op == OP_FAIL) begin
            if (st_fail < DOWN_LIMIT) begin
                n_fail = st_fail + FAIL_W'(1);
            end
        end else if (r_op == OP_SUCCESS) begin
            n_fail = '0;
        end
    end

    always_comb begin
        st_wr         = '0;
        st_fail_wdata = n_fail;
        alu_sub       = 1'b1;
        alu_b         = st_down;
        case (r_state)
            S_UPDATE: begin
                st_wr.fail_we = (r_op == OP_FAIL) || (r_op == OP_SUCCESS);
            end
            S_ARM: begin
                st_wr.down_we = 1'b1;
                alu_sub       = 1'b0;
                alu_b         = r_backoff;
            end
            default: begin
            end
        endcase
    end

    ufs_breaker_store #(
        .DEPTH (MAX_UPSTREAMS),
        .IW    (IW)
    ) u_store (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_addr  (r_k),
        .i_wr    (st_wr),
        .i_fail  (st_fail_wdata),
        .i_down  (alu_sum),
        .o_fail  (st_fail),
        .o_down  (st_down)
    );

    // now - down_until while scanning, now + backoff while arming
    ufs_time_alu u_alu (
        .i_sub (alu_sub),
        .i_a   (r_now),
        .i_b   (alu_b),
        .o_sum (alu_sum)
    );

    // config registers: always writable; the user must write them only while idle, the block does not enforce it
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_count <= COUNT_W'(1);
            r_backoff   <= BACKOFF_RESET;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                REG_COUNT:   r_cfg_count <= i_cfg_data[COUNT_W-1:0];
                REG_BACKOFF: r_backoff   <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    // sequencer and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_o_valid <= 1'b0;
        end else begin
            // the done state owns the output valid while it is waiting
            if (r_o_valid && i_ready && (r_state != S_DONE)) begin
                r_o_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (i_valid) begin
                        r_op       <= i_operation;
                        r_now      <= i_now_ms;
                        r_cnt      <= eff_cnt;
                        r_start    <= IW'(start_mod);
                        r_step     <= '0;
                        r_chosen   <= i_upstream_index;
                        r_health   <= HEALTH_OK;
                        r_all_down <= 1'b0;
                        r_invalid  <= 1'b0;
                        if (i_operation == OP_SELECT) begin
                            r_k     <= IW'(start_mod);
                            r_state <= S_SCAN;
                        end else if (!idx_in_range) begin
                            r_invalid <= 1'b1;
                            r_state   <= S_DONE;
                        end else begin
                            r_k     <= IW'(i_upstream_index);
                            r_state <= S_UPDATE;
                        end
                    end
                end
                S_SCAN: begin
                    if (st_fail < DOWN_LIMIT) begin
                        // closed breaker: take it as is
                        r_chosen <= INDEX_W'(r_k);
                        r_health <= health_of(st_fail);
                        r_state  <= S_DONE;
                    end else if (!alu_sum[TIME_W-1]) begin
                        // open breaker whose probe time has come
                        r_state <= S_ARM;
                    end else if (step_last) begin
                        // nothing qualified; every server scanned is down
                        r_chosen   <= INDEX_W'(r_start);
                        r_health   <= HEALTH_DOWN;
                        r_all_down <= 1'b1;
                        r_state    <= S_DONE;
                    end else begin
                        r_step <= r_step + COUNT_W'(1);
                        r_k    <= k_last ? '0 : r_k + IW'(1);
                    end
                end
                S_UPDATE: begin
                    r_health <= health_of(n_fail);
                    if ((r_op == OP_FAIL) && (st_fail == DOWN_LIMIT - FAIL_W'(1))) begin
                        r_state <= S_ARM;
                    end else begin
                        r_state <= S_DONE;
                    end
                end
                S_ARM: begin
                    r_chosen <= INDEX_W'(r_k);
                    r_health <= HEALTH_DOWN;
                    r_state  <= S_DONE;
                end
                S_DONE: begin
                    if (!r_o_valid || i_ready) begin
                        r_o_valid    <= 1'b1;
                        r_o_chosen   <= r_chosen;
                        r_o_health   <= r_health;
                        r_o_all_down <= r_all_down;
                        r_o_invalid  <= r_invalid;
                        r_o_count    <= r_cnt;
                        r_state      <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_ready         = (r_state == S_IDLE);
    assign o_cfg_ready     = 1'b1;
    assign o_valid         = r_o_valid;
    assign o_chosen_index  = r_o_chosen;
    assign o_health_code   = r_o_health;
    assign o_all_down      = r_o_all_down;
    assign o_index_invalid = r_o_invalid;
    assign o_active_count  = r_o_count;

endmodule

>>> sv/ufs_breaker_store.sv
// Per-server breaker state: failure count and down-until time.
// A single address serves the read and both writes; uses ufs_pkg.
module ufs_breaker_store import ufs_pkg::*; #(
    parameter int DEPTH = MAX_UPSTREAMS_DEF,
    parameter int IW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic [IW-1:0]     i_addr,
    input  t_store_wr         i_wr,
    input  logic [FAIL_W-1:0] i_fail,
    input  logic [TIME_W-1:0] i_down,
    output logic [FAIL_W-1:0] o_fail,
    output logic [TIME_W-1:0] o_down
);

    logic [FAIL_W-1:0] r_fail [DEPTH];
    logic [TIME_W-1:0] r_down [DEPTH];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < DEPTH; i++) begin
                r_fail[i] <= '0;
                r_down[i] <= '0;
            end
        end else begin
            if (i_wr.fail_we) begin
                r_fail[i_addr] <= i_fail;
            end
            if (i_wr.down_we) begin
                r_down[i_addr] <= i_down;
            end
        end
    end

    assign o_fail = r_fail[i_addr];
    assign o_down = r_down[i_addr];

endmodule

>>> sv/ufs_time_alu.sv
// Shared 32-bit add/subtract unit for probe-time checks and backoff arming.
// Uses ufs_pkg.
module ufs_time_alu import ufs_pkg::*; (
    input  logic              i_sub,
    input  logic [TIME_W-1:0] i_a,
    input  logic [TIME_W-1:0] i_b,
    output logic [TIME_W-1:0] o_sum
);

    logic [TIME_W-1:0] b_op;

    // a - b as a + ~b + 1
    assign b_op  = i_sub ? ~i_b : i_b;
    assign o_sum = i_a + b_op + TIME_W'(i_sub);

endmodule

>>> tb/tb_upstream_failover_selector.sv
// Self-checking testbench for upstream_failover_selector: directed breaker and probe cases,
// then random request traffic over several register settings. Depends on ufs_pkg and the RTL.
`timescale 1ns / 100ps

module tb_upstream_failover_selector;
    import ufs_pkg::*;

    // Operation code three has no name in the package; the block must echo it harmlessly
    localparam logic [1:0] OP_RESERVED = 2'd3;
    localparam int CYCLE_LIMIT = 500_000;
    localparam int PRINT_CAP   = 60;

    // One result as the block should present it
    typedef struct packed {
        logic [INDEX_W-1:0]  chosen;
        logic [HEALTH_W-1:0] health;
        logic                all_down;
        logic                invalid;
        logic [COUNT_W-1:0]  active;
    } t_route_result;

    logic                i_clk;
    logic                i_rst_n;
    logic                i_valid;
    logic                o_ready;
    logic [1:0]          i_operation;
    logic [INDEX_W-1:0]  i_upstream_index;
    logic [TIME_W-1:0]   i_now_ms;
    logic                o_valid;
    logic                i_ready;
    logic [INDEX_W-1:0]  o_chosen_index;
    logic [HEALTH_W-1:0] o_health_code;
    logic                o_all_down;
    logic                o_index_invalid;
    logic [COUNT_W-1:0]  o_active_count;
    logic                i_cfg_valid;
    logic                o_cfg_ready;
    logic                i_cfg_index;
    logic [TIME_W-1:0]   i_cfg_data;

    // Shadow copy of the breaker state and registers, advanced at each accepted request
    logic [FAIL_W-1:0]   fail_count [MAX_UPSTREAMS_DEF];
    logic [TIME_W-1:0]   probe_at   [MAX_UPSTREAMS_DEF];
    logic [COUNT_W-1:0]  count_reg;
    logic [TIME_W-1:0]   backoff_reg;

    t_route_result pending_routes[$];

    int          error_count;
    int          cycle_count;
    int          burst_left;
    bit          gaps_on;        // sender inserts idle gaps between bursts
    int          stall_mode;     // 0 always ready, 1 random stalls, 2 fixed pattern
    int          hold_cycles;    // long consumer hold-off, counted down by the receiver
    int          rx_phase;
    logic [31:0] now_ms;         // running time base for random traffic

    upstream_failover_selector i_dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_valid          (i_valid),
        .o_ready          (o_ready),
        .i_operation      (i_operation),
        .i_upstream_index (i_upstream_index),
        .i_now_ms         (i_now_ms),
        .o_valid          (o_valid),
        .i_ready          (i_ready),
        .o_chosen_index   (o_chosen_index),
        .o_health_code    (o_health_code),
        .o_all_down       (o_all_down),
        .o_index_invalid  (o_index_invalid),
        .o_active_count   (o_active_count),
        .i_cfg_valid      (i_cfg_valid),
        .o_cfg_ready      (o_cfg_ready),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_data       (i_cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Watchdog: the slowest legal run is far below this
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("TIMEOUT after %0d cycles", cycle_count);
            $display("DONE: errors detected");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------
    function automatic logic [HEALTH_W-1:0] breaker_health(input logic [FAIL_W-1:0] fails);
        if (fails == '0) begin
            return HEALTH_OK;
        end
        return (fails >= DOWN_LIMIT) ? HEALTH_DOWN : HEALTH_SUSPECT;
    endfunction

    // Count register of zero acts as one server; anything above storage saturates
    function automatic int servers_in_use();
        if (count_reg == '0) begin
            return 1;
        end
        if (int'(count_reg) > MAX_UPSTREAMS_DEF) begin
            return MAX_UPSTREAMS_DEF;
        end
        return int'(count_reg);
    endfunction

    task automatic route_request(input logic [1:0] op, input logic [INDEX_W-1:0] idx,
                                 input logic [TIME_W-1:0] now, output t_route_result r);
        int          cnt;
        int          i;
        int          k;
        bit          found;
        logic [31:0] lag;
        cnt        = servers_in_use();
        r.chosen   = idx;
        r.health   = HEALTH_OK;
        r.all_down = 1'b0;
        r.invalid  = 1'b0;
        r.active   = cnt[COUNT_W-1:0];
        if (op == OP_SELECT) begin
            found = 1'b0;
            for (i = 0; i < cnt && !found; i++) begin
                k = (int'(idx) + i) % cnt;
                if (fail_count[k] < DOWN_LIMIT) begin
                    r.chosen = k[INDEX_W-1:0];
                    found    = 1'b1;
                end else begin
                    // probe when the wrapped difference is non-negative
                    lag = now - probe_at[k];
                    if (!lag[31]) begin
                        probe_at[k] = now + backoff_reg;
                        r.chosen    = k[INDEX_W-1:0];
                        found       = 1'b1;
                    end
                end
            end
            if (!found) begin
                k          = int'(idx) % cnt;
                r.chosen   = k[INDEX_W-1:0];
                r.all_down = 1'b1;
            end
            r.health = breaker_health(fail_count[r.chosen]);
        end else if (int'(idx) >= MAX_UPSTREAMS_DEF) begin
            r.invalid = 1'b1;
        end else begin
            if (op == OP_FAIL) begin
                if (fail_count[idx] < DOWN_LIMIT) begin
                    fail_count[idx] = fail_count[idx] + 1'b1;
                    if (fail_count[idx] == DOWN_LIMIT) begin
                        probe_at[idx] = now + backoff_reg;
                    end
                end
            end else if (op == OP_SUCCESS) begin
                fail_count[idx] = '0;
            end
            r.health = breaker_health(fail_count[idx]);
        end
    endtask

    // ------------------------------------------------------------------
    // Result checking
    // ------------------------------------------------------------------
    task automatic report_mismatch(input string what, input logic [31:0] want,
                                   input logic [31:0] got);
        if (error_count < PRINT_CAP) begin
            $display("ERROR @%0t: %s expected %0h got %0h", $time, what, want, got);
        end
        error_count++;
    endtask

    // Outputs sampled at the rising edge, before the block updates them
    always @(posedge i_clk) begin
        t_route_result want;
        if (i_rst_n && o_valid && i_ready) begin
            if (pending_routes.size() == 0) begin
                report_mismatch("result with no request pending", 32'd0, 32'd1);
            end else begin
                want = pending_routes.pop_front();
                if (o_chosen_index !== want.chosen)
                    report_mismatch("chosen_index", 32'(want.chosen), 32'(o_chosen_index));
                if (o_health_code !== want.health)
                    report_mismatch("health_code", 32'(want.health), 32'(o_health_code));
                if (o_all_down !== want.all_down)
                    report_mismatch("all_down", 32'(want.all_down), 32'(o_all_down));
                if (o_index_invalid !== want.invalid)
                    report_mismatch("index_invalid", 32'(want.invalid),
                                    32'(o_index_invalid));
                if (o_active_count !== want.active)
                    report_mismatch("active_count", 32'(want.active), 32'(o_active_count));
            end
        end
    end

    // Consumer: a long hold-off wins, otherwise the current stall pattern applies
    initial begin
        i_ready  = 1'b0;
        rx_phase = 0;
        forever begin
            @(negedge i_clk);
            rx_phase++;
            if (hold_cycles > 0) begin
                i_ready = 1'b0;
                hold_cycles--;
            end else begin
                case (stall_mode)
                    1: begin
                        i_ready = ($urandom_range(0, 3) != 0);
                    end
                    2: begin
                        i_ready = ((rx_phase % 7) < 4);
                    end
                    default: begin
                        i_ready = 1'b1;
                    end
                endcase
            end
        end
    end

    // ------------------------------------------------------------------
    // Request driving
    // ------------------------------------------------------------------

    // Offers one request and holds it until accepted; bursts end in a random gap when gaps are on
    task automatic send_request(input logic [1:0] op, input logic [INDEX_W-1:0] idx,
                                input logic [TIME_W-1:0] now);
        t_route_result want;
        int            gap;
        @(negedge i_clk);
        i_valid          = 1'b1;
        i_operation      = op;
        i_upstream_index = idx;
        i_now_ms         = now;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        route_request(op, idx, now, want);
        pending_routes.push_back(want);
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            burst_left = $urandom_range(0, 12);
            gap        = gaps_on ? $urandom_range(1, 6) : 0;
            if (gap > 0) begin
                @(negedge i_clk);
                i_valid = 1'b0;
                repeat (gap - 1) @(negedge i_clk);
            end
        end
    endtask

    // Stop offering and let every outstanding result come back
    task automatic drain_results();
        @(negedge i_clk);
        i_valid = 1'b0;
        while (pending_routes.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    // Register writes happen only with the block idle
    task automatic write_register(input logic idx, input logic [TIME_W-1:0] data);
        drain_results();
        @(negedge i_clk);
        i_cfg_valid = 1'b1;
        i_cfg_index = idx;
        i_cfg_data  = data;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        if (idx == REG_COUNT) begin
            count_reg = data[COUNT_W-1:0];
        end else begin
            backoff_reg = data;
        end
        @(negedge i_clk);
        i_cfg_valid = 1'b0;
    endtask

    // Count field with junk in the unused upper bits
    task automatic set_server_count(input logic [COUNT_W-1:0] n);
        write_register(REG_COUNT, ($urandom() & ~32'h7) | 32'(n));
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Out of reset: one server, 30 s backoff; start index wraps onto server 0
    task automatic test_reset_defaults();
        send_request(OP_SELECT, 2'd3, 32'd0);
        send_request(OP_FAIL, 2'd2, 32'd10);
        send_request(OP_RESERVED, 2'd2, 32'hFFFF_FFFF);
        send_request(OP_SUCCESS, 2'd2, 32'd20);
        send_request(OP_SELECT, 2'd1, 32'h8000_0000);
        drain_results();
    endtask

    // Trip every breaker, hit the all-down fallback, then probe at the exact boundary
    task automatic test_breaker_trip();
        int s;
        set_server_count(3'd4);
        write_register(REG_BACKOFF, 32'd100);
        for (s = 0; s < MAX_UPSTREAMS_DEF; s++) begin
            repeat (3) send_request(OP_FAIL, s[INDEX_W-1:0], 32'd1000);
        end
        send_request(OP_FAIL, 2'd3, 32'd5000);          // saturated: no re-arm
        send_request(OP_SELECT, 2'd1, 32'd1099);        // nobody ready yet
        send_request(OP_SELECT, 2'd2, 32'd1100);        // probe due exactly now
        send_request(OP_SELECT, 2'd3, 32'd1100 + 32'h8000_0000); // far side of the wrap
        send_request(OP_SELECT, 2'd3, 32'd1100 + 32'h7FFF_FFFF); // last non-negative lag
        send_request(OP_SUCCESS, 2'd2, 32'd0);
        send_request(OP_SELECT, 2'd0, 32'd0);
        send_request(OP_RESERVED, 2'd3, 32'd0);
        drain_results();
    endtask

    // Saturated count register, all-ones backoff so the probe time wraps past zero
    task automatic test_time_wrap();
        set_server_count(3'd7);
        write_register(REG_BACKOFF, 32'hFFFF_FFFF);
        send_request(OP_SUCCESS, 2'd0, 32'd0);
        send_request(OP_SUCCESS, 2'd1, 32'd0);
        send_request(OP_SUCCESS, 2'd2, 32'd0);
        send_request(OP_SUCCESS, 2'd3, 32'd0);
        repeat (3) send_request(OP_FAIL, 2'd1, 32'hFFFF_FFF0);
        send_request(OP_SELECT, 2'd1, 32'hFFFF_FFEE);
        send_request(OP_SELECT, 2'd1, 32'hFFFF_FFEF);
        drain_results();
    endtask

    // Consumer holds off long enough that the block backs up onto its input
    task automatic test_backpressure();
        int n;
        set_server_count(3'd4);
        write_register(REG_BACKOFF, 32'd50);
        gaps_on     = 1'b0;
        stall_mode  = 0;
        hold_cycles = 300;
        for (n = 0; n < 30; n++) begin
            send_request(2'($urandom_range(0, 2)), 2'($urandom_range(0, 3)), now_ms);
            now_ms += $urandom_range(0, 40);
        end
        drain_results();
    endtask

    // Mostly failure runs and selects on an advancing clock so breakers trip and get
    // probed; time jumps land on or next to the probe boundary, a few are arbitrary
    task automatic test_random_traffic(input int n_items, input int step_max);
        int          n;
        int          r;
        logic [1:0]  op;
        logic [31:0] now;
        for (n = 0; n < n_items; n++) begin
            r = $urandom_range(0, 99);
            if (r < 45)      op = OP_SELECT;
            else if (r < 80) op = OP_FAIL;
            else if (r < 95) op = OP_SUCCESS;
            else             op = OP_RESERVED;
            r = $urandom_range(0, 99);
            if (r < 75) begin
                now_ms += $urandom_range(0, step_max);
            end else if (r < 93) begin
                now_ms += backoff_reg + $urandom_range(0, 2) - 1;
            end else begin
                now_ms = $urandom();
            end
            now = now_ms;
            send_request(op, 2'($urandom_range(0, 3)), now);
        end
        drain_results();
    endtask

    // ------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------
    initial begin
        int s;
        i_rst_n          = 1'b0;
        i_valid          = 1'b0;
        i_operation      = OP_SELECT;
        i_upstream_index = '0;
        i_now_ms         = '0;
        i_cfg_valid      = 1'b0;
        i_cfg_index      = REG_COUNT;
        i_cfg_data       = '0;
        error_count      = 0;
        cycle_count      = 0;
        burst_left       = 0;
        gaps_on          = 1'b1;
        stall_mode       = 1;
        hold_cycles      = 0;
        now_ms           = 32'd0;
        count_reg        = 3'd1;
        backoff_reg      = BACKOFF_RESET;
        for (s = 0; s < MAX_UPSTREAMS_DEF; s++) begin
            fail_count[s] = '0;
            probe_at[s]   = '0;
        end
        repeat (11) @(negedge i_clk);
        i_rst_n = 1'b1;

        test_reset_defaults();
        test_breaker_trip();
        test_time_wrap();
        test_backpressure();

        gaps_on    = 1'b1;
        stall_mode = 1;
        set_server_count(3'd4);
        write_register(REG_BACKOFF, 32'd200);
        test_random_traffic(250, 60);

        // zero count acts as one server; zero backoff re-probes at once; no idling here
        gaps_on    = 1'b0;
        stall_mode = 0;
        set_server_count(3'd0);
        write_register(REG_BACKOFF, 32'd0);
        test_random_traffic(150, 20);

        gaps_on    = 1'b1;
        stall_mode = 2;
        set_server_count(3'd7);
        write_register(REG_BACKOFF, 32'hFFFF_FFFF);
        test_random_traffic(200, 1000);

        stall_mode = 1;
        set_server_count(3'd3);
        write_register(REG_BACKOFF, 32'h7FFF_FFFF);
        test_random_traffic(200, 1000);

        stall_mode = 2;
        set_server_count(3'd2);
        write_register(REG_BACKOFF, $urandom_range(1, 500));
        test_random_traffic(200, 100);

        stall_mode = 1;
        set_server_count(3'd4);
        write_register(REG_BACKOFF, 32'd1000);
        test_random_traffic(200, 300);

        drain_results();
        repeat (20) @(posedge i_clk);
        if (error_count == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
